FILE: rtl/core/dslt_pkg.sv
// ----------------------------------------------------------------------------
// dslt_pkg
// shared types and codes of the depth sorted layer table
// ----------------------------------------------------------------------------
package dslt_pkg;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_MOVE    = 3'd1,
    OP_REPLACE = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_RESET   = 3'd4,
    OP_SWEEP   = 3'd5,
    OP_LOOKUP  = 3'd6,
    OP_LIST    = 3'd7
  } op_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOENT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef struct packed {
    op_t         op;
    logic        scan;
    logic [15:0] depth;
    logic [15:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [15:0] depth;
    logic [15:0] handle;
    logic        mark;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CK, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR, S_INS_WR,
    S_CLR_RD, S_CLR_WR, S_CNT_RD, S_CNT_CK, S_SWP_RD, S_SWP_CK,
    S_LIST_RD, S_LIST_EMIT, S_FIN
  } state_t;

endpackage

FILE: rtl/core/dslt_front.sv
// ----------------------------------------------------------------------------
// dslt_front
// accepts items, decodes the action and queues commands for the engine
// ----------------------------------------------------------------------------
module dslt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    in_action,
  input  logic [15:0]   in_depth,
  input  logic [15:0]   in_handle,
  output logic          cmd_valid,
  output dslt_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import dslt_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       dec;
  logic       push;

  // decode: actions that address one depth need a search first
  always_comb begin
    dec.op     = op_t'(in_action);
    dec.depth  = in_depth;
    dec.handle = in_handle;
    dec.scan   = dec.op inside {OP_ADD, OP_MOVE, OP_REPLACE, OP_REMOVE, OP_LOOKUP};
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

FILE: rtl/core/dslt_engine.sv
// ----------------------------------------------------------------------------
// dslt_engine
// executes commands on the sorted entry memory and drives the result register
// ----------------------------------------------------------------------------
module dslt_engine #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  dslt_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_status,
  output logic [15:0]    out_entry_handle,
  output logic           out_freed,
  output logic [15:0]    out_entry_depth,
  output logic           out_referenced,
  output logic [6:0]     out_entry_count,
  output logic           out_last
);
  import dslt_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  ent_t mem [CAPACITY];
  ent_t rdata_r;
  logic we, re;
  logic [IW-1:0] waddr, raddr;
  ent_t wdata;

  state_t st_r, st_nxt;
  cmd_t   cmd_r, cmd_nxt;
  logic [CW-1:0] fill_r, fill_nxt, idx_r, idx_nxt, wr_r, wr_nxt;
  logic [CW-1:0] kept_r, kept_nxt, ecnt_r, ecnt_nxt;
  logic [CW-1:0] wr_dec;
  logic [1:0]    fin_r, fin_nxt;

  logic          ov_r;
  logic [1:0]    o_st_r;
  logic [15:0]   o_h_r, o_d_r;
  logic          o_fr_r, o_rf_r, o_last_r;
  logic [CW-1:0] o_cnt_r;
  logic [31:0]   cnt_wide;

  logic          ld, can_ld;
  logic [1:0]    l_st;
  logic [15:0]   l_h, l_d;
  logic          l_fr, l_rf, l_last;
  logic [CW-1:0] l_cnt;
  logic          found, in_rng, nmark;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign can_ld = !ov_r || !out_stall;
  assign in_rng = (idx_r < fill_r);
  assign found  = in_rng && (rdata_r.depth == cmd_r.depth);
  assign wr_dec = wr_r - ONE;

  always_comb begin
    st_nxt = st_r; cmd_nxt = cmd_r; fill_nxt = fill_r; idx_nxt = idx_r;
    wr_nxt = wr_r; kept_nxt = kept_r; ecnt_nxt = ecnt_r; fin_nxt = fin_r;
    cmd_pop = 1'b0;
    we = 1'b0; waddr = idx_r[IW-1:0]; wdata = rdata_r;
    re = 1'b0; raddr = idx_r[IW-1:0];
    ld = 1'b0; l_st = STAT_OK; l_h = '0; l_d = '0; l_fr = 1'b0; l_rf = 1'b0;
    l_last = 1'b1; l_cnt = fill_r;
    nmark = rdata_r.mark;
    case (st_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          idx_nxt = '0;
          kept_nxt = '0;
          if (cmd.scan) st_nxt = S_SCAN_RD;
          else begin
            case (cmd.op)
              OP_RESET: st_nxt = S_CLR_RD;
              OP_SWEEP: st_nxt = S_CNT_RD;
              default: begin
                if (fill_r == '0) begin
                  fin_nxt = STAT_EMPTY;
                  st_nxt  = S_FIN;
                end else st_nxt = S_LIST_RD;
              end
            endcase
          end
        end
      end
      S_SCAN_RD: begin
        if (in_rng) begin
          re = 1'b1;
          st_nxt = S_SCAN_CK;
        end else st_nxt = S_DECIDE;
      end
      S_SCAN_CK: begin
        if (rdata_r.depth >= cmd_r.depth) st_nxt = S_DECIDE;
        else begin
          idx_nxt = idx_r + ONE;
          st_nxt = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        if (can_ld) begin
          ld = 1'b1;
          st_nxt = S_IDLE;
          wdata = '{depth: cmd_r.depth, handle: cmd_r.handle, mark: 1'b1};
          if (cmd_r.op == OP_ADD || cmd_r.op == OP_REPLACE) begin
            if (found) begin
              we = 1'b1;
              l_h = rdata_r.handle; l_fr = 1'b1; l_d = cmd_r.depth; l_rf = 1'b1;
            end else if (cmd_r.op == OP_REPLACE && in_rng) begin
              l_st = STAT_NOENT;
            end else if (fill_r >= CAP) begin
              l_st = STAT_FULL; l_d = cmd_r.depth;
            end else begin
              // insert: open a hole at idx by shifting the tail up
              l_h = cmd_r.handle; l_d = cmd_r.depth; l_rf = 1'b1;
              l_cnt = fill_r + ONE;
              wr_nxt = fill_r;
              st_nxt = S_SHIFT_RD;
            end
          end else if (found) begin
            if (cmd_r.op == OP_MOVE) nmark = 1'b1;
            else if (cmd_r.op == OP_REMOVE) nmark = 1'b0;
            we = (cmd_r.op != OP_LOOKUP);
            wdata = '{depth: rdata_r.depth, handle: rdata_r.handle, mark: nmark};
            l_h = rdata_r.handle; l_d = cmd_r.depth; l_rf = nmark;
          end else begin
            l_st = (fill_r == '0) ? STAT_EMPTY : STAT_NOENT;
          end
        end
      end
      S_SHIFT_RD: begin
        if (wr_r > idx_r) begin
          re = 1'b1;
          raddr = wr_dec[IW-1:0];
          st_nxt = S_SHIFT_WR;
        end else st_nxt = S_INS_WR;
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        waddr = wr_r[IW-1:0];
        wr_nxt = wr_dec;
        st_nxt = S_SHIFT_RD;
      end
      S_INS_WR: begin
        we = 1'b1;
        wdata = '{depth: cmd_r.depth, handle: cmd_r.handle, mark: 1'b1};
        fill_nxt = fill_r + ONE;
        st_nxt = S_IDLE;
      end
      S_CLR_RD: begin
        if (in_rng) begin
          re = 1'b1;
          st_nxt = S_CLR_WR;
        end else begin
          fin_nxt = STAT_OK;
          st_nxt = S_FIN;
        end
      end
      S_CLR_WR: begin
        we = 1'b1;
        wdata.mark = 1'b0;
        idx_nxt = idx_r + ONE;
        st_nxt = S_CLR_RD;
      end
      S_CNT_RD: begin
        if (in_rng) begin
          re = 1'b1;
          st_nxt = S_CNT_CK;
        end else begin
          idx_nxt = '0; wr_nxt = '0; ecnt_nxt = '0;
          if (kept_r == fill_r) begin
            fin_nxt = STAT_OK;
            st_nxt = S_FIN;
          end else st_nxt = S_SWP_RD;
        end
      end
      S_CNT_CK: begin
        if (rdata_r.mark) kept_nxt = kept_r + ONE;
        idx_nxt = idx_r + ONE;
        st_nxt = S_CNT_RD;
      end
      S_SWP_RD: begin
        if (in_rng) begin
          re = 1'b1;
          st_nxt = S_SWP_CK;
        end else begin
          fill_nxt = kept_r;
          st_nxt = S_IDLE;
        end
      end
      S_SWP_CK: begin
        if (rdata_r.mark) begin
          we = 1'b1;
          waddr = wr_r[IW-1:0];
          wr_nxt = wr_r + ONE;
          idx_nxt = idx_r + ONE;
          st_nxt = S_SWP_RD;
        end else if (can_ld) begin
          ld = 1'b1;
          l_h = rdata_r.handle; l_fr = 1'b1; l_d = rdata_r.depth;
          l_cnt = kept_r;
          l_last = ((ecnt_r + ONE) == (fill_r - kept_r));
          ecnt_nxt = ecnt_r + ONE;
          idx_nxt = idx_r + ONE;
          st_nxt = S_SWP_RD;
        end
      end
      S_LIST_RD: begin
        re = 1'b1;
        st_nxt = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        if (can_ld) begin
          ld = 1'b1;
          l_h = rdata_r.handle; l_d = rdata_r.depth; l_rf = rdata_r.mark;
          l_last = ((idx_r + ONE) == fill_r);
          idx_nxt = idx_r + ONE;
          st_nxt = l_last ? S_IDLE : S_LIST_RD;
        end
      end
      S_FIN: begin
        if (can_ld) begin
          ld = 1'b1;
          l_st = fin_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      fill_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      if (ld) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    idx_r  <= idx_nxt;
    wr_r   <= wr_nxt;
    kept_r <= kept_nxt;
    ecnt_r <= ecnt_nxt;
    fin_r  <= fin_nxt;
    if (ld) begin
      o_st_r   <= l_st;
      o_h_r    <= l_h;
      o_fr_r   <= l_fr;
      o_d_r    <= l_d;
      o_rf_r   <= l_rf;
      o_cnt_r  <= l_cnt;
      o_last_r <= l_last;
    end
  end

  assign cnt_wide         = 32'(o_cnt_r);
  assign out_valid        = ov_r;
  assign out_status       = o_st_r;
  assign out_entry_handle = o_h_r;
  assign out_freed        = o_fr_r;
  assign out_entry_depth  = o_d_r;
  assign out_referenced   = o_rf_r;
  assign out_entry_count  = cnt_wide[6:0];
  assign out_last         = o_last_r;

endmodule

FILE: rtl/core/depth_sorted_layer_table.sv
// ----------------------------------------------------------------------------
// depth_sorted_layer_table
// table of up to CAPACITY entries kept in ascending depth order
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one action (add, move, replace, remove, reset, sweep,
//   lookup, list); a transfer happens when in_valid is high and in_stall low
//   out_* carries the results, one transfer each; out_last marks the final
//   result of an action, every action gives at least one
//   a two-entry command queue lets the sender keep transferring while the
//   engine works; the engine takes one action at a time
//   single-depth actions walk the entries up to the depth; add with insert
//   also shifts the entries above it; reset and list walk every entry;
//   sweep counts over every entry and, if any are unmarked, compacts them
//   the entry memory has registered read data: each entry visited takes a
//   read state and then a check, write or emit state
//   reset (rst_n low at a clock edge) empties the table and drops queued
//   and pending results; no clearing pass is needed
//   when the receiver holds out_stall the result register keeps its value
//   and the engine waits on its next result, the queue keeps filling
// ----------------------------------------------------------------------------
module depth_sorted_layer_table #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_depth,
  input  logic [15:0] in_handle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_entry_handle,
  output logic        out_freed,
  output logic [15:0] out_entry_depth,
  output logic        out_referenced,
  output logic [6:0]  out_entry_count,
  output logic        out_last
);
  import dslt_pkg::*;

  // decoded commands between front and engine
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: decode and queue
  dslt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_depth  (in_depth),
    .in_handle (in_handle),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // engine: search, shift, compact and report
  dslt_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_entry_handle (out_entry_handle),
    .out_freed        (out_freed),
    .out_entry_depth  (out_entry_depth),
    .out_referenced   (out_referenced),
    .out_entry_count  (out_entry_count),
    .out_last         (out_last)
  );

endmodule

FILE: verif/tb_depth_sorted_layer_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_sorted_layer_table
// self-checking bench for the depth sorted layer table
// ----------------------------------------------------------------------------
// each accepted action is run through a behavioral copy of the sorted table;
// the results it yields are queued and every result transfer from the block
// is compared field by field against the oldest queued one. directed tests
// cover every action, field extremes, full and empty tables and the replace
// fallback; random tests run mark/sweep cycles over a narrow depth range so
// that hits, displacement and a full table happen often
// ----------------------------------------------------------------------------
module tb_depth_sorted_layer_table;
  import dslt_pkg::*;

  localparam int CAP = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ehandle;
    logic        freed;
    logic [15:0] edepth;
    logic        refd;
    logic [6:0]  count;
    logic        last;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [15:0] in_depth;
  logic [15:0] in_handle;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [15:0] out_entry_handle;
  logic        out_freed;
  logic [15:0] out_entry_depth;
  logic        out_referenced;
  logic [6:0]  out_entry_count;
  logic        out_last;

  depth_sorted_layer_table #(.CAPACITY(CAP)) uut (.*);

  // table shadow kept in depth order
  logic [15:0] tbl_depth [CAP];
  logic [15:0] tbl_handle [CAP];
  logic        tbl_mark [CAP];
  int          tbl_fill;

  result_t pending_results[$];
  int      mismatches;
  int      results_seen;
  int      cycle_count;
  int      actions_sent;
  bit      hold_receiver;   // receiver holds out_stall high while set
  int      hold_cycles;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---- table prediction ----
  function automatic void push_result(logic [1:0] st, logic [15:0] h, logic fr,
                                      logic [15:0] d, logic rf);
    result_t r;
    r.status  = st;
    r.ehandle = h;
    r.freed   = fr;
    r.edepth  = d;
    r.refd    = rf;
    r.count   = tbl_fill[6:0];
    r.last    = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic int first_not_below(logic [15:0] d);
    int i;
    i = 0;
    while (i < tbl_fill && tbl_depth[i] < d) i++;
    return i;
  endfunction

  function automatic void table_add(logic [15:0] d, logic [15:0] h);
    int i;
    logic [15:0] old;
    i = first_not_below(d);
    if (i < tbl_fill && tbl_depth[i] == d) begin
      old = tbl_handle[i];
      tbl_handle[i] = h;
      tbl_mark[i] = 1'b1;
      push_result(STAT_OK, old, 1'b1, d, 1'b1);
    end else if (tbl_fill >= CAP) begin
      push_result(STAT_FULL, '0, 1'b0, d, 1'b0);
    end else begin
      for (int j = tbl_fill; j > i; j--) begin
        tbl_depth[j]  = tbl_depth[j-1];
        tbl_handle[j] = tbl_handle[j-1];
        tbl_mark[j]   = tbl_mark[j-1];
      end
      tbl_depth[i] = d;
      tbl_handle[i] = h;
      tbl_mark[i] = 1'b1;
      tbl_fill++;
      push_result(STAT_OK, h, 1'b0, d, 1'b1);
    end
  endfunction

  function automatic void predict_action(op_t op, logic [15:0] d, logic [15:0] h);
    int i, w, first_new;
    logic [1:0] miss;
    logic [15:0] old;
    miss = (tbl_fill == 0) ? STAT_EMPTY : STAT_NOENT;
    first_new = pending_results.size();
    case (op)
      OP_ADD: table_add(d, h);
      OP_REPLACE: begin
        i = first_not_below(d);
        if (i >= tbl_fill) begin
          table_add(d, h);
        end else if (tbl_depth[i] != d) begin
          push_result(STAT_NOENT, '0, 1'b0, '0, 1'b0);
        end else begin
          old = tbl_handle[i];
          tbl_handle[i] = h;
          tbl_mark[i] = 1'b1;
          push_result(STAT_OK, old, 1'b1, d, 1'b1);
        end
      end
      OP_MOVE, OP_REMOVE, OP_LOOKUP: begin
        i = first_not_below(d);
        if (i >= tbl_fill || tbl_depth[i] != d) begin
          push_result(miss, '0, 1'b0, '0, 1'b0);
        end else begin
          if (op == OP_MOVE) tbl_mark[i] = 1'b1;
          else if (op == OP_REMOVE) tbl_mark[i] = 1'b0;
          push_result(STAT_OK, tbl_handle[i], 1'b0, d, tbl_mark[i]);
        end
      end
      OP_RESET: begin
        for (int j = 0; j < CAP; j++) tbl_mark[j] = 1'b0;
        push_result(STAT_OK, '0, 1'b0, '0, 1'b0);
      end
      OP_SWEEP: begin
        w = 0;
        for (int j = 0; j < tbl_fill; j++) begin
          if (tbl_mark[j]) begin
            tbl_depth[w] = tbl_depth[j];
            tbl_handle[w] = tbl_handle[j];
            tbl_mark[w] = 1'b1;
            w++;
          end else begin
            push_result(STAT_OK, tbl_handle[j], 1'b1, tbl_depth[j], 1'b0);
          end
        end
        for (int j = w; j < CAP; j++) tbl_mark[j] = 1'b0;
        tbl_fill = w;
        // freed entries report the count left after the sweep
        for (int k = first_new; k < pending_results.size(); k++)
          pending_results[k].count = tbl_fill[6:0];
        if (pending_results.size() == first_new)
          push_result(STAT_OK, '0, 1'b0, '0, 1'b0);
      end
      default: begin
        if (tbl_fill == 0) push_result(STAT_EMPTY, '0, 1'b0, '0, 1'b0);
        else
          for (int j = 0; j < tbl_fill; j++)
            push_result(STAT_OK, tbl_handle[j], 1'b0, tbl_depth[j], tbl_mark[j]);
      end
    endcase
    pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  // ---- sender ----
  // offer one action after a random gap and hold it until the transfer;
  // valid stays high after the transfer until a gap or a drain drops it
  task automatic send_action(op_t op, logic [15:0] d, logic [15:0] h, bit gaps = 1);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                  : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= op;
    in_depth  <= d;
    in_handle <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer happened at this edge
    predict_action(op, d, h);
    actions_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand16();
    return 16'($urandom_range(0, 65535));
  endfunction

  // ---- receiver: random stalls, plus a long forced hold ----
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_receiver) begin
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0:       out_stall <= 1'b1;
        1:       out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // long receiver hold counted in its own process
  initial begin
    hold_receiver = 1'b0;
    wait (hold_cycles > 0);
    @(posedge clk);
    hold_receiver <= 1'b1;
    repeat (hold_cycles) @(posedge clk);
    hold_receiver <= 1'b0;
  end

  // ---- result checking ----
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_entry_handle, out_freed, out_entry_depth,
             out_referenced, out_entry_count, out_last};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---- tests ----
  task automatic test_empty_table();
    // every action but add on an empty table, replace past end falls back to add
    send_action(OP_LIST, 16'h0000, 16'h0000);
    send_action(OP_LOOKUP, 16'hFFFF, 16'hFFFF);
    send_action(OP_MOVE, 16'h0000, 16'h0000);
    send_action(OP_REMOVE, 16'h1234, 16'h0000);
    send_action(OP_SWEEP, 16'h0000, 16'h0000);
    send_action(OP_RESET, 16'h0000, 16'h0000);
    send_action(OP_REPLACE, 16'h8000, 16'hA5A5);
  endtask

  task automatic test_directed_actions();
    send_action(OP_ADD, 16'h0000, 16'hFFFF);
    send_action(OP_ADD, 16'hFFFF, 16'h0000);
    send_action(OP_ADD, 16'h8000, 16'h5A5A);     // lands between the two
    send_action(OP_ADD, 16'h8000, 16'hC3C3);     // displaces same depth
    send_action(OP_REPLACE, 16'h4000, 16'h1111); // miss below a larger depth
    send_action(OP_REPLACE, 16'hFFFF, 16'h2222); // hit swaps handle
    send_action(OP_LOOKUP, 16'h8000, 16'h0000);
    send_action(OP_REMOVE, 16'h8000, 16'h0000);
    send_action(OP_REMOVE, 16'h8001, 16'h0000);  // remove needs exact depth
    send_action(OP_MOVE, 16'h0001, 16'h0000);
    send_action(OP_LIST, 16'h0000, 16'h0000);
    send_action(OP_SWEEP, 16'h0000, 16'h0000);
    send_action(OP_RESET, 16'h0000, 16'h0000);
    send_action(OP_MOVE, 16'hFFFF, 16'h0000);
    send_action(OP_SWEEP, 16'h0000, 16'h0000);
    send_action(OP_LIST, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  // fill to capacity with the receiver held off, so the input stalls too
  task automatic test_full_table();
    hold_cycles = 400;
    for (int k = 0; k < CAP + 2; k++)
      send_action(OP_ADD, 16'(k * 997 + 3), rand16(), 0);
    send_action(OP_ADD, 16'h7777, 16'h1234);
    send_action(OP_LIST, 16'h0000, 16'h0000);
    send_action(OP_RESET, 16'h0000, 16'h0000);
    send_action(OP_SWEEP, 16'h0000, 16'h0000);  // frees every entry
    wait_drained();
  endtask

  // mark-and-sweep rounds over a narrow depth window with random content
  task automatic test_random_rounds(int n_items);
    int sent;
    int base;
    op_t op;
    logic [15:0] d;
    sent = 0;
    while (sent < n_items) begin
      base = $urandom_range(0, 65535 - 96);
      repeat ($urandom_range(6, 24)) begin
        if ($urandom_range(0, 9) == 0) begin
          op = op_t'($urandom_range(0, 7));
          d  = rand16();
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2: op = OP_ADD;
            3:       op = OP_REPLACE;
            4:       op = OP_MOVE;
            5:       op = OP_REMOVE;
            6:       op = OP_LOOKUP;
            7:       op = OP_RESET;
            8:       op = OP_SWEEP;
            default: op = OP_LIST;
          endcase
          d = 16'(base + $urandom_range(0, 95));
        end
        send_action(op, d, rand16());
        sent++;
      end
      // in about one round of four the sender pauses until every result is back
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = OP_ADD;
    in_depth = '0;
    in_handle = '0;
    tbl_fill = 0;
    for (int j = 0; j < CAP; j++) begin
      tbl_depth[j] = '0;
      tbl_handle[j] = '0;
      tbl_mark[j] = 1'b0;
    end
    mismatches = 0;
    results_seen = 0;
    cycle_count = 0;
    actions_sent = 0;
    hold_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_directed_actions();
    test_full_table();
    test_random_rounds(190);

    // drain margin for the longest action
    repeat (4 * CAP + 20) @(posedge clk);
    $display("covered %0d actions and %0d result transfers, incl. full table,",
             actions_sent, results_seen);
    $display("empty table, displacement, replace fallback and mark/sweep rounds");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               pending_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
